// ----- hdl/btn_evt_pkg.sv -----
// shared types and constants of the button click event detector
`timescale 1ns / 1ps

package btn_evt_pkg;

   localparam int THRESH_WIDTH = 16;
   localparam int CSR_ADDR_WIDTH = 3;

   // register indexes on the csr port
   localparam logic [CSR_ADDR_WIDTH-1:0] REG_ACTIVE_LEVEL        = 3'd0;
   localparam logic [CSR_ADDR_WIDTH-1:0] REG_DOUBLE_CLICK_ENABLE = 3'd1;
   localparam logic [CSR_ADDR_WIDTH-1:0] REG_LONG_PRESS_ENABLE   = 3'd2;
   localparam logic [CSR_ADDR_WIDTH-1:0] REG_PRESS_DEBOUNCE      = 3'd3;
   localparam logic [CSR_ADDR_WIDTH-1:0] REG_RELEASE_DEBOUNCE    = 3'd4;
   localparam logic [CSR_ADDR_WIDTH-1:0] REG_LONG_PRESS          = 3'd5;
   localparam logic [CSR_ADDR_WIDTH-1:0] REG_CLICK_CONFIRM       = 3'd6;

   // detector modes
   localparam logic [1:0] MODE_IDLE    = 2'd0;
   localparam logic [1:0] MODE_PRESSED = 2'd1;
   localparam logic [1:0] MODE_AWAIT   = 2'd2;
   localparam logic [1:0] MODE_LONG    = 2'd3;

   typedef struct packed {
      logic                    active_level;
      logic                    double_click_enable;
      logic                    long_press_enable;
      logic [THRESH_WIDTH-1:0] press_debounce_ticks;
      logic [THRESH_WIDTH-1:0] release_debounce_ticks;
      logic [THRESH_WIDTH-1:0] long_press_ticks;
      logic [THRESH_WIDTH-1:0] click_confirm_ticks;
   } cfg_type;

   // member order matches rsp_tdata from the highest bit down
   typedef struct packed {
      logic click_long_press_event;
      logic long_press_event;
      logic double_click_event;
      logic click_event;
      logic released_event;
      logic pressed_event;
   } evt_type;

endpackage

// ----- hdl/btn_evt_fsm.sv -----
// mode machine and tick counters of the button click event detector
`timescale 1ns / 1ps

module btn_evt_fsm #(
   parameter int COUNT_WIDTH = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic                 button_level,
   input  btn_evt_pkg::cfg_type cfg,
   output btn_evt_pkg::evt_type evt
);

   localparam int CMP_WIDTH = (COUNT_WIDTH > btn_evt_pkg::THRESH_WIDTH) ?
                              COUNT_WIDTH : btn_evt_pkg::THRESH_WIDTH;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

   logic [1:0]             mode_ff, mode_in;
   logic [COUNT_WIDTH-1:0] press_count_ff, press_count_in;
   logic [COUNT_WIDTH-1:0] release_count_ff, release_count_in;
   logic                   debounced_ff, debounced_in;

   logic                   active;
   logic [COUNT_WIDTH-1:0] press_inc, release_inc;

   function automatic logic gt(input logic [COUNT_WIDTH-1:0] c,
                               input logic [btn_evt_pkg::THRESH_WIDTH-1:0] t);
      logic [CMP_WIDTH-1:0] ce;
      logic [CMP_WIDTH-1:0] te;
      ce = CMP_WIDTH'(c);
      te = CMP_WIDTH'(t);
      return ce > te;
   endfunction

   assign active      = (button_level == cfg.active_level);
   assign press_inc   = (press_count_ff == COUNT_MAX) ? COUNT_MAX : press_count_ff + 1'b1;
   assign release_inc = (release_count_ff == COUNT_MAX) ? COUNT_MAX :
                        release_count_ff + 1'b1;

   always_comb begin
      mode_in          = mode_ff;
      press_count_in   = press_count_ff;
      release_count_in = release_count_ff;
      debounced_in     = debounced_ff;
      evt              = '0;
      unique case (mode_ff) inside
         btn_evt_pkg::MODE_IDLE: begin
            if (active) begin
               mode_in = btn_evt_pkg::MODE_PRESSED;
            end
         end
         btn_evt_pkg::MODE_PRESSED, btn_evt_pkg::MODE_AWAIT: begin
            if (active) begin
               press_count_in   = press_inc;
               release_count_in = '0;
               if (!debounced_ff && gt(press_inc, cfg.press_debounce_ticks)) begin
                  evt.pressed_event = 1'b1;
                  debounced_in      = 1'b1;
               end
               if (cfg.long_press_enable && gt(press_inc, cfg.long_press_ticks)) begin
                  // a second press after a click reports its own long event
                  if (mode_ff == btn_evt_pkg::MODE_PRESSED) begin
                     evt.long_press_event = 1'b1;
                  end else begin
                     evt.click_long_press_event = 1'b1;
                  end
                  press_count_in = '0;
                  debounced_in   = 1'b0;
                  mode_in        = btn_evt_pkg::MODE_LONG;
               end
            end else begin
               release_count_in = release_inc;
               press_count_in   = '0;
               if (mode_ff == btn_evt_pkg::MODE_PRESSED) begin
                  if (!debounced_ff) begin
                     // short bounce back to idle
                     release_count_in = '0;
                     mode_in          = btn_evt_pkg::MODE_IDLE;
                  end else if (gt(release_inc, cfg.release_debounce_ticks)) begin
                     release_count_in   = '0;
                     debounced_in       = 1'b0;
                     evt.released_event = 1'b1;
                     if (cfg.double_click_enable) begin
                        mode_in = btn_evt_pkg::MODE_AWAIT;
                     end else begin
                        evt.click_event = 1'b1;
                        mode_in         = btn_evt_pkg::MODE_IDLE;
                     end
                  end
               end else begin
                  if (debounced_ff) begin
                     if (gt(release_inc, cfg.release_debounce_ticks)) begin
                        evt.released_event     = 1'b1;
                        evt.double_click_event = 1'b1;
                        debounced_in           = 1'b0;
                        mode_in                = btn_evt_pkg::MODE_IDLE;
                     end
                  end else if (gt(release_inc, cfg.click_confirm_ticks)) begin
                     evt.click_event = 1'b1;
                     mode_in         = btn_evt_pkg::MODE_IDLE;
                  end
               end
            end
         end
         default: begin
            if (active) begin
               release_count_in = '0;
            end else begin
               release_count_in = release_inc;
               if (gt(release_inc, cfg.release_debounce_ticks)) begin
                  evt.released_event = 1'b1;
                  mode_in            = btn_evt_pkg::MODE_IDLE;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff          <= btn_evt_pkg::MODE_IDLE;
         press_count_ff   <= '0;
         release_count_ff <= '0;
         debounced_ff     <= 1'b0;
      end else if (step) begin
         mode_ff          <= mode_in;
         press_count_ff   <= press_count_in;
         release_count_ff <= release_count_in;
         debounced_ff     <= debounced_in;
      end
   end

endmodule

// ----- hdl/button_click_event_detector_top.sv -----
// top level of the button click event detector
`timescale 1ns / 1ps

// Button click event detector for one key.
// req channel: one request per sampling tick, req_tdata[0] is the raw pin level.
// rsp channel: one result per request, six one-tick event flags in rsp_tdata.
// csr port: write-only registers, taken on any clock edge with csr_wr_en high;
// write them only while no request is in flight.
// Pipeline: a request is held in an input register, then the mode machine
// updates its counters and loads the result register, from which the result
// shows on rsp.
// Throughput: one request per cycle while rsp_tready is high; the tick update
// is a single pass through the mode machine between input and result registers.
// Reset: synchronous; mode goes idle, counters and the debounced flag clear, and
// the registers take their defaults (active low, double click and long press
// enabled, debounce 2, long press 100, click confirm 30 ticks).
// Stall: while rsp_tready is low the result holds, the input register fills,
// and req_tready then drops; no request is lost or repeated.
module button_click_event_detector_top #(
   parameter int COUNT_WIDTH = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [7:0]                             req_tdata,  // [0] button_level
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // [0] pressed, [1] released, [2] click, [3] double click, [4] long press,
   // [5] click long press events
   output logic [7:0]                             rsp_tdata,
   input  logic                                   csr_wr_en,
   input  logic [btn_evt_pkg::CSR_ADDR_WIDTH-1:0] csr_addr,
   input  logic [btn_evt_pkg::THRESH_WIDTH-1:0]   csr_wdata
);

   btn_evt_pkg::cfg_type cfg_ff;
   btn_evt_pkg::evt_type evt;
   btn_evt_pkg::evt_type evt_ff;

   logic in_valid_ff;
   logic level_ff;
   logic rsp_valid_ff;
   logic out_free;
   logic step;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign step       = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.active_level           <= 1'b0;
         cfg_ff.double_click_enable    <= 1'b1;
         cfg_ff.long_press_enable      <= 1'b1;
         cfg_ff.press_debounce_ticks   <= 16'd2;
         cfg_ff.release_debounce_ticks <= 16'd2;
         cfg_ff.long_press_ticks       <= 16'd100;
         cfg_ff.click_confirm_ticks    <= 16'd30;
      end else if (csr_wr_en) begin
         unique case (csr_addr)
            btn_evt_pkg::REG_ACTIVE_LEVEL:        cfg_ff.active_level <= csr_wdata[0];
            btn_evt_pkg::REG_DOUBLE_CLICK_ENABLE: cfg_ff.double_click_enable <= csr_wdata[0];
            btn_evt_pkg::REG_LONG_PRESS_ENABLE:   cfg_ff.long_press_enable <= csr_wdata[0];
            btn_evt_pkg::REG_PRESS_DEBOUNCE:      cfg_ff.press_debounce_ticks <= csr_wdata;
            btn_evt_pkg::REG_RELEASE_DEBOUNCE:    cfg_ff.release_debounce_ticks <= csr_wdata;
            btn_evt_pkg::REG_LONG_PRESS:          cfg_ff.long_press_ticks <= csr_wdata;
            btn_evt_pkg::REG_CLICK_CONFIRM:       cfg_ff.click_confirm_ticks <= csr_wdata;
            default: begin
               // unused index, write dropped
            end
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         level_ff <= req_tdata[0];
      end
   end

   btn_evt_fsm #(
      .COUNT_WIDTH(COUNT_WIDTH)
   ) u_fsm (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .button_level(level_ff),
      .cfg         (cfg_ff),
      .evt         (evt)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         evt_ff <= evt;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, evt_ff};

endmodule

// ----- bench/tb_button_click_event_detector_top.sv -----
`timescale 1ns / 1ps
// testbench for the button click event detector: tick stimulus, event prediction, checking

module tb_button_click_event_detector_top;

   localparam int CNT_W = 16;
   localparam logic [btn_evt_pkg::CSR_ADDR_WIDTH-1:0] REG_UNUSED = 3'd7;
   localparam int CYCLE_LIMIT = 100000;
   localparam int LONG_HOLD = 200;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [7:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   logic csr_wr_en = 1'b0;
   logic [btn_evt_pkg::CSR_ADDR_WIDTH-1:0] csr_addr = '0;
   logic [btn_evt_pkg::THRESH_WIDTH-1:0] csr_wdata = '0;

   logic pending_levels[$];
   btn_evt_pkg::evt_type expected_events[$];
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   bit hold_toggle = 1'b0;
   bit hold_seen = 1'b0;
   int hold_left = 0;
   int items_sent = 0;
   int results_seen = 0;
   int fail_count = 0;
   int setting_count = 0;
   int event_hits[6] = '{0, 0, 0, 0, 0, 0};
   longint cycle_count = 0;
   string event_names[6] = '{"pressed_event", "released_event", "click_event",
                             "double_click_event", "long_press_event",
                             "click_long_press_event"};

   // shadow of the detector
   btn_evt_pkg::cfg_type cfg_shadow;
   logic [1:0] det_mode;
   logic [CNT_W-1:0] press_cnt;
   logic [CNT_W-1:0] release_cnt;
   logic deb_pressed;

   button_click_event_detector_top #(
      .COUNT_WIDTH(CNT_W)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic logic [CNT_W-1:0] sat_inc(logic [CNT_W-1:0] c);
      return (c == '1) ? c : c + 1'b1;
   endfunction

   // one tick of the click detector, updates the shadow state
   function automatic btn_evt_pkg::evt_type predict_events(logic level);
      btn_evt_pkg::evt_type ev;
      logic active;
      ev = '0;
      active = (level == cfg_shadow.active_level);
      case (det_mode) inside
         btn_evt_pkg::MODE_IDLE: begin
            if (active) det_mode = btn_evt_pkg::MODE_PRESSED;
         end
         btn_evt_pkg::MODE_PRESSED, btn_evt_pkg::MODE_AWAIT: begin
            if (active) begin
               press_cnt = sat_inc(press_cnt);
               release_cnt = '0;
               if (!deb_pressed && press_cnt > cfg_shadow.press_debounce_ticks) begin
                  ev.pressed_event = 1'b1;
                  deb_pressed = 1'b1;
               end
               if (cfg_shadow.long_press_enable && press_cnt > cfg_shadow.long_press_ticks) begin
                  if (det_mode == btn_evt_pkg::MODE_PRESSED) ev.long_press_event = 1'b1;
                  else ev.click_long_press_event = 1'b1;
                  press_cnt = '0;
                  deb_pressed = 1'b0;
                  det_mode = btn_evt_pkg::MODE_LONG;
               end
            end else begin
               release_cnt = sat_inc(release_cnt);
               press_cnt = '0;
               if (det_mode == btn_evt_pkg::MODE_PRESSED) begin
                  if (!deb_pressed) begin
                     // short bounce goes straight back to idle
                     release_cnt = '0;
                     det_mode = btn_evt_pkg::MODE_IDLE;
                  end else if (release_cnt > cfg_shadow.release_debounce_ticks) begin
                     release_cnt = '0;
                     deb_pressed = 1'b0;
                     ev.released_event = 1'b1;
                     if (cfg_shadow.double_click_enable) begin
                        det_mode = btn_evt_pkg::MODE_AWAIT;
                     end else begin
                        ev.click_event = 1'b1;
                        det_mode = btn_evt_pkg::MODE_IDLE;
                     end
                  end
               end else if (deb_pressed) begin
                  if (release_cnt > cfg_shadow.release_debounce_ticks) begin
                     ev.released_event = 1'b1;
                     ev.double_click_event = 1'b1;
                     deb_pressed = 1'b0;
                     det_mode = btn_evt_pkg::MODE_IDLE;
                  end
               end else if (release_cnt > cfg_shadow.click_confirm_ticks) begin
                  ev.click_event = 1'b1;
                  det_mode = btn_evt_pkg::MODE_IDLE;
               end
            end
         end
         default: begin
            if (active) begin
               release_cnt = '0;
            end else begin
               release_cnt = sat_inc(release_cnt);
               if (release_cnt > cfg_shadow.release_debounce_ticks) begin
                  ev.released_event = 1'b1;
                  det_mode = btn_evt_pkg::MODE_IDLE;
               end
            end
         end
      endcase
      return ev;
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         det_mode = btn_evt_pkg::MODE_IDLE;
         press_cnt = '0;
         release_cnt = '0;
         deb_pressed = 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_events.push_back(predict_events(req_tdata[0]));
            items_sent++;
         end
         if (!req_tvalid || req_tready) begin
            if (pending_levels.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
               req_tvalid <= 1'b1;
               req_tdata <= {7'b0, pending_levels.pop_front()};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold, counted down in cycles
   always @(posedge clock) begin
      if (hold_toggle != hold_seen) begin
         hold_seen <= hold_toggle;
         hold_left <= LONG_HOLD;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // result monitor
   always @(posedge clock) begin
      logic [5:0] want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (expected_events.size() == 0) begin
               $error("result %b with no request outstanding", rsp_tdata);
               fail_count++;
            end else begin
               want = expected_events.pop_front();
               for (int i = 0; i < 6; i++) begin
                  event_hits[i] += want[i];
                  if (rsp_tdata[i] !== want[i]) begin
                     $error("result %0d %s: expected %b, got %b", results_seen,
                            event_names[i], want[i], rsp_tdata[i]);
                     fail_count++;
                  end
               end
            end
         end
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("cycle limit hit, %0d results still outstanding", expected_events.size());
         $display("** button_click_event_detector_top: FAILED **");
         $finish;
      end
   end

   task automatic write_reg(logic [btn_evt_pkg::CSR_ADDR_WIDTH-1:0] addr,
                            logic [btn_evt_pkg::THRESH_WIDTH-1:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_addr <= addr;
      csr_wdata <= value;
      case (addr)
         btn_evt_pkg::REG_ACTIVE_LEVEL:        cfg_shadow.active_level = value[0];
         btn_evt_pkg::REG_DOUBLE_CLICK_ENABLE: cfg_shadow.double_click_enable = value[0];
         btn_evt_pkg::REG_LONG_PRESS_ENABLE:   cfg_shadow.long_press_enable = value[0];
         btn_evt_pkg::REG_PRESS_DEBOUNCE:      cfg_shadow.press_debounce_ticks = value;
         btn_evt_pkg::REG_RELEASE_DEBOUNCE:    cfg_shadow.release_debounce_ticks = value;
         btn_evt_pkg::REG_LONG_PRESS:          cfg_shadow.long_press_ticks = value;
         btn_evt_pkg::REG_CLICK_CONFIRM:       cfg_shadow.click_confirm_ticks = value;
         default: ;
      endcase
   endtask

   // all registers, one-bit ones with junk in the upper bits
   task automatic set_config(logic act, logic dc_en, logic lp_en, int pdb, int rdb, int lpt,
                             int cct);
      logic [btn_evt_pkg::THRESH_WIDTH-1:0] junk;
      junk = 16'($urandom);
      write_reg(btn_evt_pkg::REG_ACTIVE_LEVEL, {junk[15:1], act});
      junk = 16'($urandom);
      write_reg(btn_evt_pkg::REG_DOUBLE_CLICK_ENABLE, {junk[15:1], dc_en});
      junk = 16'($urandom);
      write_reg(REG_UNUSED, junk);
      junk = 16'($urandom);
      write_reg(btn_evt_pkg::REG_LONG_PRESS_ENABLE, {junk[15:1], lp_en});
      write_reg(btn_evt_pkg::REG_PRESS_DEBOUNCE, pdb[15:0]);
      write_reg(btn_evt_pkg::REG_RELEASE_DEBOUNCE, rdb[15:0]);
      write_reg(btn_evt_pkg::REG_LONG_PRESS, lpt[15:0]);
      write_reg(btn_evt_pkg::REG_CLICK_CONFIRM, cct[15:0]);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
      setting_count++;
   endtask

   task automatic push_run(logic level, int n);
      repeat (n) pending_levels.push_back(level);
   endtask

   // mostly press and release runs around the thresholds, some raw noise
   task automatic queue_clicks(int n);
      int added;
      int lim_p;
      int lim_r;
      int len;
      logic act;
      act = cfg_shadow.active_level;
      lim_p = (cfg_shadow.long_press_ticks > 56) ? 60 : cfg_shadow.long_press_ticks + 4;
      lim_r = (cfg_shadow.click_confirm_ticks > cfg_shadow.release_debounce_ticks) ?
              cfg_shadow.click_confirm_ticks : cfg_shadow.release_debounce_ticks;
      lim_r = (lim_r > 56) ? 60 : lim_r + 4;
      added = 0;
      while (added < n) begin
         if ($urandom_range(9, 0) < 2) begin
            len = $urandom_range(8, 1);
            repeat (len) pending_levels.push_back(1'($urandom));
            added += len;
         end else begin
            len = $urandom_range(lim_p, 1);
            push_run(act, len);
            added += len;
            if ($urandom_range(4, 0) == 0) begin
               // bounce inside the press
               push_run(!act, 1);
               push_run(act, 2);
               added += 3;
            end
            len = $urandom_range(lim_r, 0);
            push_run(!act, len);
            added += len;
         end
      end
   endtask

   task automatic wait_idle();
      while (pending_levels.size() != 0 || req_tvalid || expected_events.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic set_pace(int send_pct, int recv_pct);
      send_idle_pct = send_pct;
      recv_stall_pct = recv_pct;
   endtask

   initial begin
      logic directed_levels[$];
      cfg_shadow.active_level = 1'b0;
      cfg_shadow.double_click_enable = 1'b1;
      cfg_shadow.long_press_enable = 1'b1;
      cfg_shadow.press_debounce_ticks = 16'd2;
      cfg_shadow.release_debounce_ticks = 16'd2;
      cfg_shadow.long_press_ticks = 16'd100;
      cfg_shadow.click_confirm_ticks = 16'd30;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // short bounce, click pair into double click, leftover release count after it,
      // press held to the long press threshold but not past it, second double click
      set_config(1'b1, 1'b1, 1'b1, 1, 1, 4, 2);
      directed_levels = '{0, 1, 0, 1, 1, 1, 0, 0, 1, 1, 1, 0, 0,
                          1, 1, 1, 1, 1, 0, 0, 1, 0, 1, 1, 1, 0, 0, 0, 0, 0};
      foreach (directed_levels[i]) pending_levels.push_back(directed_levels[i]);
      wait_idle();

      // threshold extremes
      set_config(1'b0, 1'b1, 1'b1, 0, 0, 0, 0);
      queue_clicks(110);
      wait_idle();
      set_pace(33, 33);
      set_config(1'b1, 1'b1, 1'b1, 0, 0, 65535, 65535);
      queue_clicks(110);
      wait_idle();
      set_pace(0, 0);
      set_config(1'b0, 1'b0, 1'b1, 65535, 65535, 65535, 65535);
      queue_clicks(40);
      wait_idle();

      for (int p = 0; p < 8; p++) begin
         case (p % 4)
            0: set_pace(0, 0);
            1: set_pace(69, 0);
            2: set_pace(0, 69);
            default: set_pace(33, 33);
         endcase
         set_config(1'($urandom), 1'($urandom), 1'($urandom), $urandom_range(3, 0),
                    $urandom_range(3, 0), $urandom_range(25, 0), $urandom_range(12, 0));
         queue_clicks(200);
         if (p == 4) begin
            // receiver holds off while the sender keeps offering
            set_pace(0, 0);
            hold_toggle = !hold_toggle;
         end
         wait_idle();
      end

      $display("%0d ticks checked under %0d register settings, %0d results", items_sent,
               setting_count, results_seen);
      $display("events: pressed %0d released %0d click %0d double %0d long %0d click-long %0d",
               event_hits[0], event_hits[1], event_hits[2], event_hits[3], event_hits[4],
               event_hits[5]);
      if (fail_count == 0 && expected_events.size() == 0) begin
         $display("** button_click_event_detector_top: PASSED **");
      end else begin
         $display("** button_click_event_detector_top: FAILED **");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
hdl/btn_evt_pkg.sv
hdl/btn_evt_fsm.sv
hdl/button_click_event_detector_top.sv
bench/tb_button_click_event_detector_top.sv
